@@ rtl/vnts_pkg.sv @@
// Shared types and codes of the value noise trilinear sampler.
package vnts_pkg;

	localparam int ENTRY_IDX_BITS   = 4;
	localparam int ENTRY_VALUE_BITS = 15;
	localparam int POINT_BITS       = 32;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// Fields of a lattice write, x in the lowest bits.
	typedef struct packed {
		logic [ENTRY_VALUE_BITS-1:0] value;
		logic [ENTRY_IDX_BITS-1:0]   z;
		logic [ENTRY_IDX_BITS-1:0]   y;
		logic [ENTRY_IDX_BITS-1:0]   x;
	} entry_t;

endpackage

@@ rtl/vnts_bank.sv @@
// One copy of the lattice sample memory with a registered read port.
module vnts_bank #(
	parameter int DEPTH = 4096,
	parameter int DATA_BITS = 15,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 rd_en,
	input  logic [AW-1:0]        raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/vnts_addr.sv @@
// Front pipeline: coordinate magnitudes, lattice wrap and corner addresses.
module vnts_addr #(
	parameter int LATTICE_SIZE = 16,
	parameter int SAMPLE_BITS = 15,
	parameter int FRACTION_BITS = 16,
	localparam int AW = $clog2(LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  vnts_pkg::cmd_t           in_cmd,
	input  vnts_pkg::entry_t         in_entry,
	input  logic [31:0]              in_px,
	input  logic [31:0]              in_py,
	input  logic [31:0]              in_pz,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_sample,
	output logic                     out_wr_en,
	output logic [AW-1:0]            out_wr_addr,
	output logic [SAMPLE_BITS-1:0]   out_wr_data,
	output logic [AW-1:0]            out_corner_addr [8],
	output logic [FRACTION_BITS-1:0] out_frac [3]
);
	import vnts_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int IB = 32 - FRACTION_BITS;
	localparam int LB = $clog2(LATTICE_SIZE);
	localparam int RS = IB + LB;
	// Reciprocal of the lattice size; the quotient estimate is exact or one low.
	localparam longint unsigned RECIP = (64'd1 << RS) / LATTICE_SIZE;
	localparam logic [RS-1:0] RECIP_V = RS'(RECIP);

	function automatic logic [AW-1:0] lat_addr(input logic [AW-1:0] x,
			input logic [AW-1:0] y, input logic [AW-1:0] z);
		return x * AW'(LATTICE_SIZE * LATTICE_SIZE) + y * AW'(LATTICE_SIZE) + z;
	endfunction

	logic ld1, ld2, ld3, ld4, ld5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign ld5 = !v_s5 || out_ready;
	assign ld4 = !v_s4 || ld5;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign in_ready  = ld1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
		end
	end

	// Stage 1: magnitudes.
	logic [31:0] pt [3];
	logic [31:0] mag_c [3];
	logic [31:0] mag_s1 [3];
	cmd_t        cmd_s1;
	entry_t      entry_s1;

	assign pt[0] = in_px;
	assign pt[1] = in_py;
	assign pt[2] = in_pz;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag_c[a] = pt[a][31] ? (~pt[a] + 32'd1) : pt[a];
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			cmd_s1   <= in_cmd;
			entry_s1 <= in_entry;
			for (int a = 0; a < 3; a++) begin
				mag_s1[a] <= mag_c[a];
			end
		end
	end

	// Stage 2: multiply the integer part by the reciprocal.
	logic [IB+RS-1:0] prod_s2 [3];
	logic [IB-1:0]    n_s2 [3];
	logic [F-1:0]     frac_s2 [3];
	cmd_t             cmd_s2;
	entry_t           entry_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			cmd_s2   <= cmd_s1;
			entry_s2 <= entry_s1;
			for (int a = 0; a < 3; a++) begin
				n_s2[a]    <= mag_s1[a][31:F];
				frac_s2[a] <= mag_s1[a][F-1:0];
				prod_s2[a] <= (IB+RS)'(mag_s1[a][31:F]) * (IB+RS)'(RECIP_V);
			end
		end
	end

	// Stage 3: raw remainder, below twice the lattice size.
	logic [IB-1:0] rem_c [3];
	logic [LB:0]   r_s3 [3];
	logic [F-1:0]  frac_s3 [3];
	cmd_t          cmd_s3;
	entry_t        entry_s3;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rem_c[a] = n_s2[a] - prod_s2[a][IB+RS-1:RS] * IB'(LATTICE_SIZE);
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			cmd_s3   <= cmd_s2;
			entry_s3 <= entry_s2;
			for (int a = 0; a < 3; a++) begin
				r_s3[a]    <= rem_c[a][LB:0];
				frac_s3[a] <= frac_s2[a];
			end
		end
	end

	// Stage 4: corrected index and its wrapped neighbor.
	logic [LB:0]   rfix_c [3];
	logic [LB-1:0] i0_c [3];
	logic [LB-1:0] i0_s4 [3];
	logic [LB-1:0] i1_s4 [3];
	logic [F-1:0]  frac_s4 [3];
	cmd_t          cmd_s4;
	entry_t        entry_s4;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rfix_c[a] = (r_s3[a] >= (LB+1)'(LATTICE_SIZE)) ?
				r_s3[a] - (LB+1)'(LATTICE_SIZE) : r_s3[a];
			i0_c[a] = rfix_c[a][LB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			cmd_s4   <= cmd_s3;
			entry_s4 <= entry_s3;
			for (int a = 0; a < 3; a++) begin
				i0_s4[a]   <= i0_c[a];
				i1_s4[a]   <= (i0_c[a] == LB'(LATTICE_SIZE - 1)) ? '0 : i0_c[a] + 1'b1;
				frac_s4[a] <= frac_s3[a];
			end
		end
	end

	// Stage 5: memory addresses for the eight corners and for a write.
	logic                   in_range_c;
	logic [30:0]            value_ext;
	logic [AW-1:0]          corner_c [8];
	logic [AW-1:0]          corner_s5 [8];
	logic [F-1:0]           frac_s5 [3];
	logic                   sample_s5;
	logic                   wr_en_s5;
	logic [AW-1:0]          wr_addr_s5;
	logic [SAMPLE_BITS-1:0] wr_data_s5;

	assign in_range_c = (7'(entry_s4.x) < 7'(LATTICE_SIZE)) &&
		(7'(entry_s4.y) < 7'(LATTICE_SIZE)) && (7'(entry_s4.z) < 7'(LATTICE_SIZE));
	assign value_ext = 31'(entry_s4.value);

	// Corner c selects the +1 neighbor in x by bit 2, in y by bit 1, in z by bit 0.
	always_comb begin
		for (int c = 0; c < 8; c++) begin
			corner_c[c] = lat_addr(AW'(c[2] ? i1_s4[0] : i0_s4[0]),
				AW'(c[1] ? i1_s4[1] : i0_s4[1]), AW'(c[0] ? i1_s4[2] : i0_s4[2]));
		end
	end

	always_ff @(posedge clk) begin
		if (ld5) begin
			sample_s5  <= (cmd_s4 == CMD_SAMPLE);
			wr_en_s5   <= (cmd_s4 == CMD_WRITE) && in_range_c;
			wr_addr_s5 <= lat_addr(AW'(entry_s4.x), AW'(entry_s4.y), AW'(entry_s4.z));
			wr_data_s5 <= value_ext[SAMPLE_BITS-1:0];
			for (int c = 0; c < 8; c++) begin
				corner_s5[c] <= corner_c[c];
			end
			for (int a = 0; a < 3; a++) begin
				frac_s5[a] <= frac_s4[a];
			end
		end
	end

	assign out_sample  = sample_s5;
	assign out_wr_en   = wr_en_s5;
	assign out_wr_addr = wr_addr_s5;
	assign out_wr_data = wr_data_s5;

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			out_corner_addr[c] = corner_s5[c];
		end
		for (int a = 0; a < 3; a++) begin
			out_frac[a] = frac_s5[a];
		end
	end

endmodule

@@ rtl/vnts_interp.sv @@
// Back pipeline: blends the eight corner samples along x, y and then z.
module vnts_interp #(
	parameter int SAMPLE_BITS = 15,
	parameter int FRACTION_BITS = 16,
	localparam int OW = SAMPLE_BITS + FRACTION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SAMPLE_BITS-1:0]   corner [8],
	input  logic [FRACTION_BITS-1:0] frac [3],
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OW-1:0]            out_value
);

	localparam int SB = SAMPLE_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int DW = SB + 1;
	localparam int PW = SB + F + 2;

	// (b - a) * f as a signed product.
	function automatic logic signed [PW-1:0] mul_diff(input logic [SB-1:0] a,
			input logic [SB-1:0] b, input logic [F-1:0] f);
		logic signed [DW-1:0] d;
		logic signed [F:0]    fe;
		d  = DW'({1'b0, b}) - DW'({1'b0, a});
		fe = {1'b0, f};
		return d * fe;
	endfunction

	// a + floor(p / 2^F); the arithmetic shift floors negative products too.
	function automatic logic [SB-1:0] add_floor(input logic [SB-1:0] a,
			input logic signed [PW-1:0] p);
		logic signed [PW-1:0] sh;
		logic [SB+1:0]        s;
		sh = p >>> F;
		s  = {2'b00, a} + sh[SB+1:0];
		return s[SB-1:0];
	endfunction

	logic ld7, ld8, ld9, ld10, ld11, ld12;
	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	assign ld12 = !v_s12 || out_ready;
	assign ld11 = !v_s11 || ld12;
	assign ld10 = !v_s10 || ld11;
	assign ld9  = !v_s9 || ld10;
	assign ld8  = !v_s8 || ld9;
	assign ld7  = !v_s7 || ld8;
	assign in_ready  = ld7;
	assign out_valid = v_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (ld7)  v_s7  <= in_valid;
			if (ld8)  v_s8  <= v_s7;
			if (ld9)  v_s9  <= v_s8;
			if (ld10) v_s10 <= v_s9;
			if (ld11) v_s11 <= v_s10;
			if (ld12) v_s12 <= v_s11;
		end
	end

	// Index j = {y, z} selects the pair of corners blended along x.
	logic signed [PW-1:0] px_s7 [4];
	logic [SB-1:0]        ax_s7 [4];
	logic [F-1:0]         fy_s7, fz_s7;
	logic [SB-1:0]        bx_s8 [4];
	logic [F-1:0]         fy_s8, fz_s8;

	always_ff @(posedge clk) begin
		if (ld7) begin
			fy_s7 <= frac[1];
			fz_s7 <= frac[2];
			for (int j = 0; j < 4; j++) begin
				ax_s7[j] <= corner[j];
				px_s7[j] <= mul_diff(corner[j], corner[4+j], frac[0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld8) begin
			fy_s8 <= fy_s7;
			fz_s8 <= fz_s7;
			for (int j = 0; j < 4; j++) begin
				bx_s8[j] <= add_floor(ax_s7[j], px_s7[j]);
			end
		end
	end

	// Index k is the z layer.
	logic signed [PW-1:0] py_s9 [2];
	logic [SB-1:0]        ay_s9 [2];
	logic [F-1:0]         fz_s9;
	logic [SB-1:0]        by_s10 [2];
	logic [F-1:0]         fz_s10;

	always_ff @(posedge clk) begin
		if (ld9) begin
			fz_s9 <= fz_s8;
			for (int k = 0; k < 2; k++) begin
				ay_s9[k] <= bx_s8[k];
				py_s9[k] <= mul_diff(bx_s8[k], bx_s8[2+k], fy_s8);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld10) begin
			fz_s10 <= fz_s9;
			for (int k = 0; k < 2; k++) begin
				by_s10[k] <= add_floor(ay_s9[k], py_s9[k]);
			end
		end
	end

	// The z blend keeps its fraction bits.
	logic signed [PW-1:0] pz_s11;
	logic [SB-1:0]        az_s11;
	logic [OW-1:0]        value_s12;

	always_ff @(posedge clk) begin
		if (ld11) begin
			az_s11 <= by_s10[0];
			pz_s11 <= mul_diff(by_s10[0], by_s10[1], fz_s10);
		end
	end

	always_ff @(posedge clk) begin
		if (ld12) begin
			value_s12 <= {az_s11, {F{1'b0}}} + pz_s11[OW-1:0];
		end
	end

	assign out_value = value_s12;

endmodule

@@ rtl/value_noise_trilinear_sampler.sv @@
// Top level of the value noise trilinear sampler.
// A transfer with tuser = 0 writes one lattice entry; one with tuser = 1 samples the
// lattice at a signed Q16.16 point and yields one unnormalized result with
// FRACTION_BITS fraction bits. Write transfers produce no result. The block takes one
// transfer per clock and keeps taking them while earlier results wait on the master
// side; a sample result passes through the address, memory read and blend stages, each stage stalling
// only when it and everything after it are full. The eight corners are read in the same
// cycle from eight copies of the lattice, each copy written by every write transfer,
// so reads and writes take effect in stream order. The lattice holds no defined value
// until written, and sampling must touch only entries that were written.
module value_noise_trilinear_sampler #(
	parameter int LATTICE_SIZE = 16,
	parameter int SAMPLE_BITS = 15,
	parameter int FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_x, entry_y, entry_z, entry_value, point_x, point_y, point_z, zero fill
	input  logic [127:0] s_tdata,
	// command
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// noise_value, zero fill
	output logic [((SAMPLE_BITS+FRACTION_BITS+7)/8)*8-1:0] m_tdata
);
	import vnts_pkg::*;

	localparam int DEPTH = LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int OW    = SAMPLE_BITS + FRACTION_BITS;
	localparam int OBW   = ((SAMPLE_BITS + FRACTION_BITS + 7) / 8) * 8;

	cmd_t   in_cmd;
	entry_t in_entry;

	assign in_cmd   = cmd_t'(s_tuser[0]);
	assign in_entry = entry_t'(s_tdata[26:0]);

	logic                     a_valid, a_ready, a_sample, a_wr_en;
	logic [AW-1:0]            a_wr_addr;
	logic [SAMPLE_BITS-1:0]   a_wr_data;
	logic [AW-1:0]            a_corner [8];
	logic [FRACTION_BITS-1:0] a_frac [3];

	vnts_addr #(
		.LATTICE_SIZE (LATTICE_SIZE),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_addr (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_cmd         (in_cmd),
		.in_entry       (in_entry),
		.in_px          (s_tdata[58:27]),
		.in_py          (s_tdata[90:59]),
		.in_pz          (s_tdata[122:91]),
		.out_valid      (a_valid),
		.out_ready      (a_ready),
		.out_sample     (a_sample),
		.out_wr_en      (a_wr_en),
		.out_wr_addr    (a_wr_addr),
		.out_wr_data    (a_wr_data),
		.out_corner_addr(a_corner),
		.out_frac       (a_frac)
	);

	// Stage 6 is the memory read; writes land on the same edge, in stream order.
	logic                     v_s6;
	logic                     ld6;
	logic                     i_ready;
	logic                     mem_we;
	logic [SAMPLE_BITS-1:0]   corner_s6 [8];
	logic [FRACTION_BITS-1:0] frac_s6 [3];

	assign ld6     = !v_s6 || i_ready;
	assign a_ready = ld6;
	assign mem_we  = ld6 && a_valid && a_wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (ld6) begin
			v_s6 <= a_valid && a_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (ld6) begin
			for (int a = 0; a < 3; a++) begin
				frac_s6[a] <= a_frac[a];
			end
		end
	end

	for (genvar c = 0; c < 8; c++) begin : g_bank
		vnts_bank #(
			.DEPTH    (DEPTH),
			.DATA_BITS(SAMPLE_BITS)
		) u_bank (
			.clk  (clk),
			.we   (mem_we),
			.waddr(a_wr_addr),
			.wdata(a_wr_data),
			.rd_en(ld6),
			.raddr(a_corner[c]),
			.rdata(corner_s6[c])
		);
	end

	logic [OW-1:0] noise_value;

	vnts_interp #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s6),
		.in_ready (i_ready),
		.corner   (corner_s6),
		.frac     (frac_s6),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_value(noise_value)
	);

	assign m_tdata = OBW'(noise_value);

endmodule

@@ tb/value_noise_trilinear_sampler_tb.sv @@
// Self-checking testbench of the value noise trilinear sampler, with its own noise predictor.
module value_noise_trilinear_sampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vnts_pkg::*;

	localparam int FRAC_W = 16;
	localparam int NOISE_W = 31;
	localparam int TARGET_ITEMS = 1850;
	localparam logic [NOISE_W-1:0] FULL_SCALE_NOISE = 31'h7FFF_0000;

	typedef struct {
		cmd_t                        cmd;
		logic [ENTRY_IDX_BITS-1:0]   ex;
		logic [ENTRY_IDX_BITS-1:0]   ey;
		logic [ENTRY_IDX_BITS-1:0]   ez;
		logic [ENTRY_VALUE_BITS-1:0] ev;
		logic [POINT_BITS-1:0]       px;
		logic [POINT_BITS-1:0]       py;
		logic [POINT_BITS-1:0]       pz;
		bit                          typed;
		logic [NOISE_W-1:0]          noise;
	} stim_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// entry_x, entry_y, entry_z, entry_value, point_x, point_y, point_z, zero fill
	logic [127:0] s_tdata = '0;
	// command
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// noise_value, zero fill
	logic [31:0]  m_tdata;

	// Expectation typed into the table travels beside the transfer it belongs to.
	bit                 offer_typed = 1'b0;
	logic [NOISE_W-1:0] offer_noise = '0;

	logic [ENTRY_VALUE_BITS-1:0] lattice_mem [0:4095];
	bit                          written_map [0:4095];
	logic [NOISE_W-1:0]          noise_expected [$];

	int items_sent = 0;
	int fail_count = 0;
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	bit rx_hold_req = 1'b0;
	bit rx_hold_taken = 1'b0;
	int rx_hold_left = 0;

	stim_t directed_rows [22];

	value_noise_trilinear_sampler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] magnitude(logic [31:0] p);
		return p[31] ? (~p + 32'd1) : p;
	endfunction

	// a + floor((b - a) * f / 2^16); the arithmetic shift floors negative products.
	function automatic longint lerp_floor(longint a, longint b, longint f);
		longint prod;
		prod = (b - a) * f;
		return a + (prod >>> FRAC_W);
	endfunction

	function automatic logic [NOISE_W-1:0] predict_noise(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		logic [31:0] mx, my, mz;
		logic [3:0] x0, y0, z0, x1, y1, z1;
		longint fx, fy, fz, a00, a01, a10, a11, b0, b1, res;
		mx = magnitude(px);
		my = magnitude(py);
		mz = magnitude(pz);
		x0 = mx[19:16];
		y0 = my[19:16];
		z0 = mz[19:16];
		x1 = x0 + 4'd1;
		y1 = y0 + 4'd1;
		z1 = z0 + 4'd1;
		fx = longint'(mx[15:0]);
		fy = longint'(my[15:0]);
		fz = longint'(mz[15:0]);
		a00 = lerp_floor(longint'(lattice_mem[{x0, y0, z0}]),
			longint'(lattice_mem[{x1, y0, z0}]), fx);
		a01 = lerp_floor(longint'(lattice_mem[{x0, y0, z1}]),
			longint'(lattice_mem[{x1, y0, z1}]), fx);
		a10 = lerp_floor(longint'(lattice_mem[{x0, y1, z0}]),
			longint'(lattice_mem[{x1, y1, z0}]), fx);
		a11 = lerp_floor(longint'(lattice_mem[{x0, y1, z1}]),
			longint'(lattice_mem[{x1, y1, z1}]), fx);
		b0 = lerp_floor(a00, a10, fy);
		b1 = lerp_floor(a01, a11, fy);
		res = b0 * (longint'(1) << FRAC_W) + (b1 - b0) * fz;
		return res[NOISE_W-1:0];
	endfunction

	function automatic stim_t wr_row(logic [3:0] x, logic [3:0] y, logic [3:0] z,
			logic [ENTRY_VALUE_BITS-1:0] v);
		stim_t r;
		r.cmd = CMD_WRITE;
		r.ex = x;
		r.ey = y;
		r.ez = z;
		r.ev = v;
		r.px = $urandom();
		r.py = $urandom();
		r.pz = $urandom();
		r.typed = 1'b0;
		r.noise = '0;
		return r;
	endfunction

	function automatic stim_t smp_row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			bit typed, logic [NOISE_W-1:0] noise);
		stim_t r;
		r.cmd = CMD_SAMPLE;
		r.ex = ENTRY_IDX_BITS'($urandom());
		r.ey = ENTRY_IDX_BITS'($urandom());
		r.ez = ENTRY_IDX_BITS'($urandom());
		r.ev = ENTRY_VALUE_BITS'($urandom());
		r.px = px;
		r.py = py;
		r.pz = pz;
		r.typed = typed;
		r.noise = noise;
		return r;
	endfunction

	function automatic logic [ENTRY_VALUE_BITS-1:0] rand_sample_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return ENTRY_VALUE_BITS'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		logic [31:0] c;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 6))
					0: c = 32'h0000_0000;
					1: c = 32'h7FFF_FFFF;
					2: c = 32'h8000_0000;
					3: c = 32'hFFFF_FFFF;
					4: c = 32'h0000_FFFF;
					5: c = 32'h0001_0000;
					default: c = 32'hFFFF_0000;
				endcase
			end
			1: begin
				c = {16'($urandom_range(0, 40)), 16'($urandom())};
				if ($urandom_range(0, 1) == 1)
					c = ~c + 32'd1;
			end
			default: c = $urandom();
		endcase
		return c;
	endfunction

	task automatic send_item(input stim_t it);
		entry_t ent;
		ent.x = it.ex;
		ent.y = it.ey;
		ent.z = it.ez;
		ent.value = it.ev;
		if (tx_idle_en && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		if (it.cmd == CMD_WRITE)
			written_map[{it.ex, it.ey, it.ez}] = 1'b1;
		s_tdata <= {5'd0, it.pz, it.py, it.px, ent};
		s_tuser <= it.cmd;
		offer_typed <= it.typed;
		offer_noise <= it.noise;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Mostly samples; any corner not yet loaded gets a write first, so no sample
	// ever touches an undefined lattice entry.
	task automatic random_step();
		stim_t it;
		logic [31:0] mx, my, mz;
		logic [3:0] cx, cy, cz;
		if ($urandom_range(0, 99) < 15) begin
			send_item(wr_row(ENTRY_IDX_BITS'($urandom()), ENTRY_IDX_BITS'($urandom()),
				ENTRY_IDX_BITS'($urandom()), rand_sample_value()));
		end else begin
			it = smp_row(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
			mx = magnitude(it.px);
			my = magnitude(it.py);
			mz = magnitude(it.pz);
			for (int i = 0; i < 8; i++) begin
				cx = i[0] ? mx[19:16] + 4'd1 : mx[19:16];
				cy = i[1] ? my[19:16] + 4'd1 : my[19:16];
				cz = i[2] ? mz[19:16] + 4'd1 : mz[19:16];
				if (!written_map[{cx, cy, cz}])
					send_item(wr_row(cx, cy, cz, rand_sample_value()));
			end
			send_item(it);
		end
	endtask

	// Accepted transfers drive the predictor in stream order.
	always @(posedge clk) begin
		entry_t ent;
		if (arst_n && s_tvalid && s_tready) begin
			ent = s_tdata[26:0];
			if (cmd_t'(s_tuser[0]) == CMD_WRITE) begin
				lattice_mem[{ent.x, ent.y, ent.z}] = ent.value;
			end else if (offer_typed) begin
				noise_expected.push_back(offer_noise);
			end else begin
				noise_expected.push_back(predict_noise(s_tdata[58:27], s_tdata[90:59],
					s_tdata[122:91]));
			end
		end
	end

	always @(posedge clk) begin
		logic [NOISE_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (noise_expected.size() == 0) begin
				$error("noise_value: no result expected, actual %0d", m_tdata[NOISE_W-1:0]);
				fail_count++;
			end else begin
				want = noise_expected.pop_front();
				if (m_tdata[NOISE_W-1:0] !== want) begin
					$error("noise_value: expected %0d, actual %0d", want,
						m_tdata[NOISE_W-1:0]);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (rx_hold_req && !rx_hold_taken) begin
			rx_hold_taken <= 1'b1;
			rx_hold_left <= 300;
			m_tready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= rx_idle_en ? ($urandom_range(0, 99) >= 20) : 1'b1;
		end
	end

	initial begin
		#2_000_000;
		$display("value_noise_trilinear_sampler_tb NOT OK");
		$finish;
	end

	initial begin
		directed_rows = '{
			wr_row(4'd0, 4'd0, 4'd0, 15'd32767),
			wr_row(4'd1, 4'd0, 4'd0, 15'd0),
			wr_row(4'd0, 4'd1, 4'd0, 15'd0),
			wr_row(4'd1, 4'd1, 4'd0, 15'd32767),
			wr_row(4'd0, 4'd0, 4'd1, 15'd0),
			wr_row(4'd1, 4'd0, 4'd1, 15'd32767),
			wr_row(4'd0, 4'd1, 4'd1, 15'd32767),
			wr_row(4'd1, 4'd1, 4'd1, 15'd0),
			smp_row(32'h0, 32'h0, 32'h0, 1'b1, FULL_SCALE_NOISE),
			// The most negative coordinate wraps onto lattice index zero.
			smp_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, FULL_SCALE_NOISE),
			smp_row(32'h8000_0000, 32'h0, 32'h8000_0000, 1'b1, FULL_SCALE_NOISE),
			smp_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0),
			smp_row(32'h0000_FFFF, 32'h0, 32'h0, 1'b0, '0),
			smp_row(32'h0, 32'h0000_FFFF, 32'h0, 1'b0, '0),
			smp_row(32'h0, 32'h0, 32'h0000_FFFF, 1'b0, '0),
			smp_row(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, '0),
			smp_row(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, '0),
			smp_row(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0, '0),
			wr_row(4'd0, 4'd0, 4'd0, 15'd0),
			smp_row(32'h0, 32'h0, 32'h0, 1'b1, '0),
			wr_row(4'd0, 4'd0, 4'd0, 15'd32767),
			smp_row(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1, FULL_SCALE_NOISE)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
		while (items_sent < 600)
			random_step();

		// Hold the receiver off while offering more, so the pipeline backs up.
		rx_hold_req <= 1'b1;
		repeat (150)
			random_step();

		// Let everything drain before going on; the wait starts only once the
		// last accepted transfer is already in the expected queue.
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (noise_expected.size() == 0);
		@(posedge clk);

		tx_idle_en = 1'b0;
		rx_idle_en <= 1'b0;
		repeat (300)
			random_step();

		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
		while (items_sent < TARGET_ITEMS)
			random_step();
		s_tvalid <= 1'b0;
		@(posedge clk);

		wait (noise_expected.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("value_noise_trilinear_sampler_tb OK");
		else
			$display("value_noise_trilinear_sampler_tb NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/vnts_pkg.sv
rtl/vnts_bank.sv
rtl/vnts_addr.sv
rtl/vnts_interp.sv
rtl/value_noise_trilinear_sampler.sv
tb/value_noise_trilinear_sampler_tb.sv
